FILE: rtl/core/rpf_pkg.sv
`timescale 1ns / 1ps
package rpf_pkg;

    localparam int MODE_W     = 4;
    localparam int FWW        = 11;
    localparam int FHW        = 13;
    localparam int BOW        = 9;
    localparam int CGW        = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [MODE_W-1:0] MODE_GRAY     = 4'd0;
    localparam logic [MODE_W-1:0] MODE_INVERT   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_BLUR     = 4'd2;
    localparam logic [MODE_W-1:0] MODE_SHARPEN  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_BRIGHT   = 4'd4;
    localparam logic [MODE_W-1:0] MODE_CONTRAST = 4'd5;
    localparam logic [MODE_W-1:0] MODE_SEPIA    = 4'd6;
    localparam logic [MODE_W-1:0] MODE_EDGE     = 4'd7;
    localparam logic [MODE_W-1:0] MODE_EMBOSS   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_WARM     = 4'd9;
    localparam logic [MODE_W-1:0] MODE_COOL     = 4'd10;
    localparam logic [MODE_W-1:0] MODE_DRAMA    = 4'd11;
    localparam logic [MODE_W-1:0] MODE_OIL      = 4'd12;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd4;

    localparam logic [MODE_W-1:0] RST_MODE   = MODE_GRAY;
    localparam logic [FWW-1:0]    RST_WIDTH  = 11'd640;
    localparam logic [FHW-1:0]    RST_HEIGHT = 13'd480;
    localparam logic [BOW-1:0]    RST_BRIGHT = 9'd50;
    localparam logic [CGW-1:0]    RST_GAIN   = 12'd384;

    // Color gains in thousandths.
    localparam int SEPIA_K [9] = '{393, 769, 189, 349, 686, 168, 272, 534, 131};
    localparam int K_1200 = 1200;
    localparam int K_1100 = 1100;
    localparam int K_1000 = 1000;
    localparam int K_900  = 900;

    typedef logic [23:0] t_pix;
    typedef t_pix [2:0][2:0] t_win;

    typedef struct packed {
        logic valid;
        logic border;
        logic fend;
    } t_tag;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [BOW-1:0]    bright;
        logic [CGW-1:0]    gain;
    } t_cfg;

    function automatic logic [7:0] chan(input t_pix p, input int k);
        return p[23-8*k -: 8];
    endfunction

    function automatic logic [7:0] sat8(input logic signed [23:0] v);
        logic [7:0] res;
        if (v < 0) begin
            res = 8'd0;
        end else if (v > 24'sd255) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/rgb_pixel_filter_engine_top.sv
`timescale 1ns / 1ps
// One word per cycle in and out while not stalled; a result passes stage 1, the window and
// filter stages a and b after the word that releases it, frame_width+1 words after its own pixel.
// The two line stores are read in the accept cycle and written back from the stage 1 registers.
// After a write to frame_height, input stalls while the current row is reduced modulo
// the new height, one bit a cycle.
// Synchronous active-low reset resets config, clears window, tags, counters; not the line stores.
module rgb_pixel_filter_engine_top #(
    parameter int MAX_WIDTH      = 1024,
    parameter int MAX_HEIGHT     = 4096,
    parameter int COEF_FRAC_BITS = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_kind,
    input  logic [7:0]                         i_red_in,
    input  logic [7:0]                         i_green_in,
    input  logic [7:0]                         i_blue_in,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [7:0]                         o_red_out,
    output logic [7:0]                         o_green_out,
    output logic [7:0]                         o_blue_out,
    output logic                               o_frame_end,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rpf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rpf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CXW = $clog2(MAX_WIDTH);
    localparam int CYW = $clog2(MAX_HEIGHT);
    localparam int CNW = $clog2(CYW);
    localparam int FWW = rpf_pkg::FWW;
    localparam int FHW = rpf_pkg::FHW;
    localparam int HCW = rpf_pkg::FWW + 1;

    logic [rpf_pkg::MODE_W-1:0] r_mode;
    logic [FWW-1:0]             r_width;
    logic [FHW-1:0]             r_height;
    logic [rpf_pkg::BOW-1:0]    r_bright;
    logic [rpf_pkg::CGW-1:0]    r_gain;

    logic [FWW-1:0] w_eff;
    logic [FHW-1:0] h_eff;

    logic [CXW-1:0] r_cx, n_cx;
    logic [CYW-1:0] r_cy, n_cy;
    logic [CYW-1:0] r_cym, n_cym;
    logic [HCW-1:0] r_held, n_held;

    logic           r_div_busy;
    logic [CNW-1:0] r_div_cnt;
    logic [FHW-1:0] r_div_rem;
    logic [FHW:0]   div_t;
    logic [FHW:0]   div_n;

    logic           advance, accept, s0_shift, s0_emit, s0_border, s0_fend;
    rpf_pkg::t_pix  s0_px;

    logic           r_s1_valid, r_s1_emit, r_s1_border, r_s1_fend;
    rpf_pkg::t_pix  r_s1_px;
    logic [CXW-1:0] r_s1_idx;
    logic           r_fwd;
    rpf_pkg::t_pix  r_fwd_up, r_fwd_mid;
    rpf_pkg::t_pix  up_rd, mid_rd, up_v, mid_v;

    rpf_pkg::t_win  r_win;
    rpf_pkg::t_tag  r_s2_tag;
    rpf_pkg::t_cfg  cfg;

    always_comb begin
        if (r_width == '0) begin
            w_eff = FWW'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_eff = FWW'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = FHW'(1);
        end else if (32'(r_height) > MAX_HEIGHT) begin
            h_eff = FHW'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    assign advance     = !o_valid || !i_stall;
    assign o_stall     = !advance || r_div_busy;
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // Item decode, position update and the position of the pixel that leaves.
    always_comb begin
        int w_i, h_i, cx1, cy1, oy1, oy2, ox, oy;
        logic [HCW-1:0] full;
        w_i  = 32'(w_eff);
        h_i  = 32'(h_eff);
        full = HCW'(w_eff) + HCW'(1);
        s0_shift = 1'b0;
        s0_emit  = 1'b0;
        n_held   = r_held;
        s0_px    = i_kind ? '0 : {i_red_in, i_green_in, i_blue_in};
        if (!i_kind) begin
            s0_shift = 1'b1;
            if (r_held >= full) begin
                s0_emit = 1'b1;
                n_held  = full;
            end else begin
                n_held = r_held + HCW'(1);
            end
        end else if (r_held != '0) begin
            s0_shift = 1'b1;
            s0_emit  = 1'b1;
            n_held   = ((r_held > full) ? full : r_held) - HCW'(1);
        end

        cx1 = 32'(r_cx) + 1;
        cy1 = 32'(r_cy) + 1;
        if (cx1 >= w_i) begin
            n_cx = '0;
            n_cy = (cy1 >= h_i) ? '0 : CYW'(cy1);
            n_cym = n_cy;
        end else begin
            n_cx  = CXW'(cx1);
            n_cy  = r_cy;
            n_cym = r_cym;
        end
        if (i_kind && n_held == '0) begin
            n_cx  = '0;
            n_cy  = '0;
            n_cym = '0;
        end

        oy1 = (r_cym == '0) ? h_i - 1 : 32'(r_cym) - 1;
        oy2 = (oy1 == 0) ? h_i - 1 : oy1 - 1;
        if (r_cx != '0) begin
            ox = 32'(r_cx) - 1;
            oy = oy1;
        end else begin
            ox = w_i - 1;
            oy = oy2;
        end
        s0_border = (ox == 0) || (ox == w_i - 1) || (oy == 0) || (oy == h_i - 1);
        s0_fend   = (ox == w_i - 1) && (oy == h_i - 1);
    end

    // Restoring remainder step: row modulo the newly written height.
    assign div_t = {r_div_rem, r_cy[r_div_cnt]};
    assign div_n = (div_t >= {1'b0, h_eff}) ? div_t - {1'b0, h_eff} : div_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= rpf_pkg::RST_MODE;
            r_width    <= rpf_pkg::RST_WIDTH;
            r_height   <= rpf_pkg::RST_HEIGHT;
            r_bright   <= rpf_pkg::RST_BRIGHT;
            r_gain     <= rpf_pkg::RST_GAIN;
            r_cx       <= '0;
            r_cy       <= '0;
            r_cym      <= '0;
            r_held     <= '0;
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
            r_div_rem  <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    rpf_pkg::REG_MODE:   r_mode   <= i_cfg_data[rpf_pkg::MODE_W-1:0];
                    rpf_pkg::REG_WIDTH:  r_width  <= i_cfg_data[FWW-1:0];
                    rpf_pkg::REG_HEIGHT: begin
                        r_height   <= i_cfg_data[FHW-1:0];
                        r_div_busy <= 1'b1;
                        r_div_cnt  <= CNW'(CYW - 1);
                        r_div_rem  <= '0;
                    end
                    rpf_pkg::REG_BRIGHT: r_bright <= i_cfg_data[rpf_pkg::BOW-1:0];
                    rpf_pkg::REG_GAIN:   r_gain   <= i_cfg_data[rpf_pkg::CGW-1:0];
                    default: ;
                endcase
            end
            if (r_div_busy && !(i_cfg_valid && i_cfg_index == rpf_pkg::REG_HEIGHT)) begin
                r_div_rem <= FHW'(div_n);
                if (r_div_cnt == '0) begin
                    r_div_busy <= 1'b0;
                    r_cym      <= CYW'(div_n);
                end else begin
                    r_div_cnt <= r_div_cnt - CNW'(1);
                end
            end
            if (accept && s0_shift) begin
                r_cx   <= n_cx;
                r_cy   <= n_cy;
                r_cym  <= n_cym;
                r_held <= n_held;
            end
        end
    end

    assign up_v  = r_fwd ? r_fwd_up : up_rd;
    assign mid_v = r_fwd ? r_fwd_mid : mid_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
            r_win      <= '0;
            r_s2_tag   <= '0;
        end else if (advance) begin
            r_s1_valid <= accept && s0_shift;
            // The line store read issued this cycle misses a write to the same column.
            r_fwd      <= r_s1_valid && (r_s1_idx == r_cx);
            if (r_s1_valid) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r][0] <= r_win[r][1];
                    r_win[r][1] <= r_win[r][2];
                end
                r_win[0][2] <= up_v;
                r_win[1][2] <= mid_v;
                r_win[2][2] <= r_s1_px;
            end
            r_s2_tag.valid  <= r_s1_valid && r_s1_emit;
            r_s2_tag.border <= r_s1_border;
            r_s2_tag.fend   <= r_s1_fend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_emit   <= s0_emit;
            r_s1_border <= s0_border;
            r_s1_fend   <= s0_fend;
            r_s1_px     <= s0_px;
            r_s1_idx    <= r_cx;
            r_fwd_up    <= mid_v;
            r_fwd_mid   <= r_s1_px;
        end
    end

    rpf_ram #(
        .WIDTH (24),
        .DEPTH (MAX_WIDTH)
    ) u_upper_ram (
        .i_clk   (i_clk),
        .i_we    (advance && r_s1_valid),
        .i_waddr (r_s1_idx),
        .i_wdata (mid_v),
        .i_re    (advance),
        .i_raddr (r_cx),
        .o_rdata (up_rd)
    );

    rpf_ram #(
        .WIDTH (24),
        .DEPTH (MAX_WIDTH)
    ) u_middle_ram (
        .i_clk   (i_clk),
        .i_we    (advance && r_s1_valid),
        .i_waddr (r_s1_idx),
        .i_wdata (r_s1_px),
        .i_re    (advance),
        .i_raddr (r_cx),
        .o_rdata (mid_rd)
    );

    assign cfg.mode   = r_mode;
    assign cfg.bright = r_bright;
    assign cfg.gain   = r_gain;

    rpf_filter #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_tag   (r_s2_tag),
        .i_win   (r_win),
        .i_cfg   (cfg),
        .o_valid (o_valid),
        .o_red   (o_red_out),
        .o_green (o_green_out),
        .o_blue  (o_blue_out),
        .o_fend  (o_frame_end)
    );

endmodule

FILE: rtl/core/rpf_ram.sv
`timescale 1ns / 1ps
module rpf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/rpf_filter.sv
`timescale 1ns / 1ps
module rpf_filter #(
    parameter int COEF_FRAC_BITS = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  rpf_pkg::t_tag i_tag,
    input  rpf_pkg::t_win i_win,
    input  rpf_pkg::t_cfg i_cfg,
    output logic          o_valid,
    output logic [7:0]    o_red,
    output logic [7:0]    o_green,
    output logic [7:0]    o_blue,
    output logic          o_fend
);

    localparam int CW = COEF_FRAC_BITS + 1;
    localparam int PW = 8 + CW;
    localparam int SW = PW + 2;
    localparam int C1200 = (rpf_pkg::K_1200 << COEF_FRAC_BITS) / 1000;
    localparam int C1100 = (rpf_pkg::K_1100 << COEF_FRAC_BITS) / 1000;
    localparam int C1000 = (rpf_pkg::K_1000 << COEF_FRAC_BITS) / 1000;
    localparam int C900  = (rpf_pkg::K_900 << COEF_FRAC_BITS) / 1000;

    rpf_pkg::t_tag r_tag_a;
    rpf_pkg::t_tag r_tag_b;

    logic [7:0]               r_c     [3];
    logic [11:0]              r_blur  [3];
    logic signed [12:0]       r_sharp [3];
    logic signed [12:0]       r_edge  [3];
    logic signed [12:0]       r_emb   [3];
    logic signed [21:0]       r_con   [3];
    logic signed [10:0]       r_bri   [3];
    logic [PW-1:0]            r_scl   [3];
    logic [PW-1:0]            r_sep   [3][3];
    logic [7:0]               n_res   [3];
    logic [7:0]               r_res   [3];
    logic [12:0]              gray_sum;
    logic [7:0]               gray;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a <= '0;
            r_tag_b <= '0;
        end else if (i_en) begin
            r_tag_a <= i_tag;
            r_tag_b <= r_tag_a;
        end
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        logic [7:0]         px [3][3];
        logic signed [12:0] q  [3][3];
        logic [11:0]        blur;
        logic signed [12:0] blur_s;
        logic signed [8:0]  dev;
        logic [CW-1:0]      k;

        for (genvar r = 0; r < 3; r++) begin : g_row
            for (genvar c = 0; c < 3; c++) begin : g_col
                assign px[r][c] = rpf_pkg::chan(i_win[r][c], ch);
                assign q[r][c]  = $signed({5'b0, px[r][c]});
            end
        end

        assign blur = 12'(px[0][0]) + 12'(px[0][1]) + 12'(px[0][2])
                    + 12'(px[1][0]) + 12'(px[1][1]) + 12'(px[1][2])
                    + 12'(px[2][0]) + 12'(px[2][1]) + 12'(px[2][2]);
        assign blur_s = $signed({1'b0, blur});
        assign dev = $signed({1'b0, px[1][1]}) - 9'sd128;

        // Per-channel gain for the warm, cool and drama tints.
        always_comb begin
            case (i_cfg.mode)
                rpf_pkg::MODE_WARM: begin
                    k = (ch == 0) ? CW'(C1200) : ((ch == 1) ? CW'(C1100) : CW'(C1000));
                end
                rpf_pkg::MODE_COOL: begin
                    k = (ch == 2) ? CW'(C1100) : CW'(C900);
                end
                default: begin
                    k = (ch == 0) ? CW'(C1200) : CW'(C900);
                end
            endcase
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_c[ch]     <= px[1][1];
                r_blur[ch]  <= blur;
                r_sharp[ch] <= 13'sd5 * q[1][1] - q[0][1] - q[1][0] - q[1][2] - q[2][1];
                r_edge[ch]  <= 13'sd9 * q[1][1] - blur_s;
                r_emb[ch]   <= q[1][1] + q[1][2] + q[2][1] + 13'sd2 * q[2][2]
                             - 13'sd2 * q[0][0] - q[0][1] - q[1][0] + 13'sd128;
                r_con[ch]   <= 22'(dev) * 22'($signed({1'b0, i_cfg.gain}));
                r_bri[ch]   <= $signed({3'b0, px[1][1]}) + 11'($signed(i_cfg.bright));
                r_scl[ch]   <= PW'(px[1][1]) * PW'(k);
            end
        end

        for (genvar i = 0; i < 3; i++) begin : g_sep
            localparam int SC = (rpf_pkg::SEPIA_K[ch*3+i] << COEF_FRAC_BITS) / 1000;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sep[ch][i] <= PW'(rpf_pkg::chan(i_win[1][1], i)) * PW'(SC);
                end
            end
        end

        logic [SW-1:0]      sep_sum;
        logic [23:0]        blur_q;
        logic signed [23:0] sep_v;
        logic signed [23:0] scl_v;
        logic signed [23:0] con_v;

        assign sep_sum = SW'(r_sep[ch][0]) + SW'(r_sep[ch][1]) + SW'(r_sep[ch][2]);
        // Divide by nine: 3641 / 2^15 is exact for sums up to nine full pixels.
        assign blur_q = 24'(r_blur[ch]) * 24'd3641;
        assign sep_v = $signed(24'(sep_sum >> COEF_FRAC_BITS));
        assign scl_v = $signed(24'(r_scl[ch] >> COEF_FRAC_BITS));
        assign con_v = 24'(r_con[ch] >>> 8) + 24'sd128;

        always_comb begin
            case (i_cfg.mode) inside
                rpf_pkg::MODE_GRAY:     n_res[ch] = gray;
                rpf_pkg::MODE_INVERT:   n_res[ch] = 8'd255 - r_c[ch];
                rpf_pkg::MODE_BLUR, rpf_pkg::MODE_OIL: begin
                    n_res[ch] = r_tag_a.border ? r_c[ch] : 8'(blur_q >> 15);
                end
                rpf_pkg::MODE_SHARPEN: begin
                    n_res[ch] = r_tag_a.border ? r_c[ch] : rpf_pkg::sat8(24'(r_sharp[ch]));
                end
                rpf_pkg::MODE_EDGE: begin
                    n_res[ch] = r_tag_a.border ? r_c[ch] : rpf_pkg::sat8(24'(r_edge[ch]));
                end
                rpf_pkg::MODE_EMBOSS: begin
                    n_res[ch] = r_tag_a.border ? r_c[ch] : rpf_pkg::sat8(24'(r_emb[ch]));
                end
                rpf_pkg::MODE_BRIGHT:   n_res[ch] = rpf_pkg::sat8(24'(r_bri[ch]));
                rpf_pkg::MODE_CONTRAST: n_res[ch] = rpf_pkg::sat8(con_v);
                rpf_pkg::MODE_SEPIA:    n_res[ch] = rpf_pkg::sat8(sep_v);
                rpf_pkg::MODE_WARM, rpf_pkg::MODE_COOL, rpf_pkg::MODE_DRAMA: begin
                    n_res[ch] = rpf_pkg::sat8(scl_v);
                end
                default:                n_res[ch] = r_c[ch];
            endcase
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_res[ch] <= n_res[ch];
            end
        end
    end

    assign gray_sum = 13'(r_c[0]) * 13'd11 + 13'(r_c[1]) * 13'd16 + 13'(r_c[2]) * 13'd5;
    assign gray = 8'(gray_sum >> 5);

    assign o_valid = r_tag_b.valid;
    assign o_fend  = r_tag_b.fend;
    assign o_red   = r_res[0];
    assign o_green = r_res[1];
    assign o_blue  = r_res[2];

endmodule
